### rtl/length_prefixed_protobuf_field_parser_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed protobuf field parser
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PROTOBUF_FIELD_PARSER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PROTOBUF_FIELD_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPP_ASSERT_NOW(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPP_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lpp_pkg.sv
// ---------------------------------------------------------------------------
// Length-prefixed protobuf parser package
// Constants, codes and types shared by the parser modules.
// ---------------------------------------------------------------------------
package lpp_pkg;

	localparam int PREFIX_BYTES = 4;
	localparam logic [3:0] VARINT_MAX_GROUPS = 4'd10;

	localparam logic [2:0] CLS_PREFIX  = 3'd0;
	localparam logic [2:0] CLS_VARINT  = 3'd1;
	localparam logic [2:0] CLS_NSPACE  = 3'd2;
	localparam logic [2:0] CLS_PAYLOAD = 3'd3;
	localparam logic [2:0] CLS_OTHER   = 3'd4;
	localparam logic [2:0] CLS_SKIP    = 3'd5;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_NSPACE  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_OTHER   = 2'd3;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LENGTH = 3'd2;

	localparam logic [60:0] FIELD_NSPACE  = 61'd4;
	localparam logic [60:0] FIELD_PAYLOAD = 61'd6;

	typedef enum logic [5:0] {
		PH_PREFIX = 6'b000001,
		PH_KEY    = 6'b000010,
		PH_VALUE  = 6'b000100,
		PH_LEN    = 6'b001000,
		PH_STRING = 6'b010000,
		PH_SKIP   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [2:0] byte_class;
		logic       message_done;
		logic       namespace_present;
		logic       parse_stopped;
		logic       length_overrun;
	} result_t;

endpackage

### rtl/lpp_parser.sv
// ---------------------------------------------------------------------------
// Parser state and per-byte decode
// Holds the framing and wire-format state and classifies one byte per step.
// ---------------------------------------------------------------------------
module lpp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	output lpp_pkg::result_t result
);
	import lpp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  prefix_count_q, prefix_count_d;
	logic [31:0] message_left_q, message_left_d;
	logic [31:0] string_left_q, string_left_d;
	logic [63:0] varint_accum_q, varint_accum_d;
	logic [3:0]  varint_group_q, varint_group_d;
	logic [1:0]  field_kind_q, field_kind_d;
	logic        namespace_flag_q, namespace_flag_d;

	logic [2:0]  prefix_next;
	logic [31:0] prefix_value;
	logic [31:0] ml_dec;
	logic [31:0] sl_dec;
	logic [63:0] acc_new;
	logic [3:0]  group_new;
	logic        more;
	logic        len_over;
	logic [1:0]  key_kind;
	logic [127:0] group_wide;

	always_comb begin
		group_wide = {121'd0, data_byte[6:0]} << (7'(varint_group_q) * 7'd7);
		acc_new    = varint_accum_q | group_wide[63:0];
		group_new  = (varint_group_q < VARINT_MAX_GROUPS) ? varint_group_q + 4'd1
			: varint_group_q;
	end

	assign more         = data_byte[7];
	assign prefix_next  = {1'b0, prefix_count_q} + 3'd1;
	assign prefix_value = {message_left_q[23:0], data_byte};
	assign ml_dec       = (message_left_q != 32'd0) ? message_left_q - 32'd1 : message_left_q;
	assign sl_dec       = (string_left_q != 32'd0) ? string_left_q - 32'd1 : string_left_q;
	assign len_over     = (acc_new[63:32] != 32'd0) || (acc_new[31:0] > ml_dec);
	assign key_kind     = (acc_new[63:3] == FIELD_NSPACE) ? KIND_NSPACE
		: (acc_new[63:3] == FIELD_PAYLOAD) ? KIND_PAYLOAD : KIND_OTHER;

	always_comb begin
		phase_d          = phase_q;
		prefix_count_d   = prefix_count_q;
		message_left_d   = message_left_q;
		string_left_d    = string_left_q;
		varint_accum_d   = varint_accum_q;
		varint_group_d   = varint_group_q;
		field_kind_d     = field_kind_q;
		namespace_flag_d = namespace_flag_q;
		result.echo_byte         = data_byte;
		result.byte_class        = CLS_PREFIX;
		result.message_done      = 1'b0;
		result.namespace_present = 1'b0;
		result.parse_stopped     = 1'b0;
		result.length_overrun    = 1'b0;

		if (phase_q == PH_PREFIX) begin
			message_left_d = prefix_value;
			if (prefix_next >= 3'(PREFIX_BYTES)) begin
				prefix_count_d = 2'd0;
				if (prefix_value == 32'd0) begin
					result.message_done = 1'b1;
					namespace_flag_d    = 1'b0;
				end else begin
					phase_d        = PH_KEY;
					varint_accum_d = 64'd0;
					varint_group_d = 4'd0;
				end
			end else begin
				prefix_count_d = prefix_next[1:0];
			end
		end else begin
			message_left_d = ml_dec;
			case (phase_q)
				PH_KEY: begin
					result.byte_class = CLS_VARINT;
					varint_accum_d    = acc_new;
					varint_group_d    = group_new;
					if (!more || ml_dec == 32'd0) begin
						varint_accum_d = 64'd0;
						varint_group_d = 4'd0;
						if (acc_new[2:0] == WT_VARINT) begin
							phase_d = PH_VALUE;
						end else if (acc_new[2:0] == WT_LENGTH) begin
							field_kind_d = key_kind;
							phase_d      = PH_LEN;
							if (ml_dec == 32'd0 && key_kind == KIND_NSPACE) begin
								namespace_flag_d = 1'b0;
							end
						end else begin
							result.parse_stopped = 1'b1;
							phase_d              = PH_SKIP;
						end
					end
				end
				PH_VALUE: begin
					result.byte_class = CLS_VARINT;
					varint_accum_d    = acc_new;
					varint_group_d    = group_new;
					if (!more || ml_dec == 32'd0) begin
						varint_accum_d = 64'd0;
						varint_group_d = 4'd0;
						phase_d        = PH_KEY;
					end
				end
				PH_LEN: begin
					result.byte_class = CLS_VARINT;
					varint_accum_d    = acc_new;
					varint_group_d    = group_new;
					if (!more || ml_dec == 32'd0) begin
						varint_accum_d = 64'd0;
						varint_group_d = 4'd0;
						if (len_over || acc_new == 64'd0) begin
							result.length_overrun = len_over;
							phase_d               = PH_KEY;
							if (field_kind_q == KIND_NSPACE) begin
								namespace_flag_d = 1'b0;
							end
						end else begin
							string_left_d = acc_new[31:0];
							phase_d       = PH_STRING;
							if (field_kind_q == KIND_NSPACE) begin
								namespace_flag_d = 1'b1;
							end
						end
					end
				end
				PH_STRING: begin
					case (field_kind_q)
						KIND_NSPACE:  result.byte_class = CLS_NSPACE;
						KIND_PAYLOAD: result.byte_class = CLS_PAYLOAD;
						default:      result.byte_class = CLS_OTHER;
					endcase
					string_left_d = sl_dec;
					if (sl_dec == 32'd0) begin
						phase_d = PH_KEY;
					end
				end
				default: begin
					result.byte_class = CLS_SKIP;
					phase_d           = PH_SKIP;
				end
			endcase
			if (ml_dec == 32'd0) begin
				result.message_done      = 1'b1;
				result.namespace_present = namespace_flag_d;
				namespace_flag_d = 1'b0;
				phase_d          = PH_PREFIX;
				prefix_count_d   = 2'd0;
				string_left_d    = 32'd0;
				varint_accum_d   = 64'd0;
				varint_group_d   = 4'd0;
				field_kind_d     = KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_PREFIX;
			prefix_count_q   <= 2'd0;
			message_left_q   <= 32'd0;
			string_left_q    <= 32'd0;
			varint_accum_q   <= 64'd0;
			varint_group_q   <= 4'd0;
			field_kind_q     <= KIND_NONE;
			namespace_flag_q <= 1'b0;
		end else if (step) begin
			phase_q          <= phase_d;
			prefix_count_q   <= prefix_count_d;
			message_left_q   <= message_left_d;
			string_left_q    <= string_left_d;
			varint_accum_q   <= varint_accum_d;
			varint_group_q   <= varint_group_d;
			field_kind_q     <= field_kind_d;
			namespace_flag_q <= namespace_flag_d;
		end
	end

endmodule

### rtl/length_prefixed_protobuf_field_parser_core.sv
// ---------------------------------------------------------------------------
// Length-prefixed protobuf field parser core
// Byte-stream parser for length-framed protobuf messages.
// ---------------------------------------------------------------------------
// Bytes enter on the s_ channel, one byte per transfer in s_tdata. Each
// message starts with a four-byte big-endian body length, followed by a body
// in protobuf wire format. For every byte one result leaves on the m_ channel:
// the byte itself in m_tdata, its class and flags in m_tuser, and m_tlast on
// the byte that ends a framed message.
// A byte is held in an input register, then decoded and written to the
// output register when that register is empty or being read, so its
// result is offered there. One byte per cycle is sustained while m_tready
// is high, limited by the single decode step between the two registers.
// While m_tready is low the output register holds its result and the input
// register keeps one more byte; s_tready drops only when both are full.
// Reset empties both registers and returns the parser to the length prefix
// of a new message with the namespace flag cleared.
// ---------------------------------------------------------------------------
module length_prefixed_protobuf_field_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] echo_byte
	output logic [5:0] m_tuser,   // [2:0] byte_class, [3] namespace_present,
	                              // [4] parse_stopped, [5] length_overrun
	output logic       m_tlast    // message_done
);
	import lpp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    result;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	lpp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.echo_byte;
	assign m_tuser  = {result_s2.length_overrun, result_s2.parse_stopped,
		result_s2.namespace_present, result_s2.byte_class};
	assign m_tlast  = result_s2.message_done;

endmodule

### rtl/lpp_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the length-prefixed protobuf field parser
// Watches the result channel of the top level for consistent flags.
// ---------------------------------------------------------------------------
`include "length_prefixed_protobuf_field_parser_core_defines.svh"

module lpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [5:0] m_tuser,
	input logic       m_tlast
);
	import lpp_pkg::*;

	`LPP_ASSERT_NOW(a_nsp_only_at_end, clk, arst_n, m_tvalid && m_tuser[3], m_tlast,
		"namespace_present without message end")

	`LPP_ASSERT_NOW(a_stop_no_overrun, clk, arst_n, m_tvalid, !(m_tuser[4] && m_tuser[5]),
		"parse_stopped and length_overrun together")

	`LPP_ASSERT_NOW(a_class_range, clk, arst_n, m_tvalid, m_tuser[2:0] <= CLS_SKIP,
		"byte class out of range")

	`LPP_ASSERT_NEXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"stalled transfer changed")

endmodule

bind length_prefixed_protobuf_field_parser_core lpp_checker u_lpp_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the length-prefixed protobuf field parser core
// Frames of protobuf wire-format fields are streamed in byte by byte with
// random gaps on both sides. Each accepted byte is run through a parser
// model kept here, and every result on the output stream is compared with
// the oldest predicted one.
// ---------------------------------------------------------------------------
module tb;
	import lpp_pkg::*;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_BYTES = 1550;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [5:0] m_tuser;
	logic       m_tlast;

	length_prefixed_protobuf_field_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	phase_t      ph = PH_PREFIX;
	int          pre_cnt = 0;
	logic [31:0] msg_left = 32'd0;
	logic [31:0] str_left = 32'd0;
	logic [63:0] acc = 64'd0;
	logic [6:0]  shift = 7'd0;
	logic [1:0]  kind = KIND_NONE;
	logic        ns_flag = 1'b0;

	result_t     parsed_bytes[$];
	result_t     want;
	logic [7:0]  body[$];
	int          n_bad = 0;
	int          n_sent = 0;
	int          stall_cycles = 0;
	bit          sender_burst = 1'b0;
	bit          ready_burst = 1'b0;
	int          ready_left = 0;
	int          hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void absorb(input logic [7:0] b);
		if (shift < 7'd64)
			acc = acc | ({57'd0, b[6:0]} << shift);
		if (shift < 7'd70)
			shift = shift + 7'd7;
	endfunction

	function automatic logic end_length(input logic [63:0] len);
		if (len > {32'd0, msg_left}) begin
			if (kind == KIND_NSPACE)
				ns_flag = 1'b0;
			ph = PH_KEY;
			return 1'b1;
		end
		if (len == 64'd0) begin
			if (kind == KIND_NSPACE)
				ns_flag = 1'b0;
			ph = PH_KEY;
			return 1'b0;
		end
		if (kind == KIND_NSPACE)
			ns_flag = 1'b1;
		str_left = len[31:0];
		ph = PH_STRING;
		return 1'b0;
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		logic [63:0] key;
		r = '0;
		r.echo_byte = b;
		r.byte_class = CLS_PREFIX;
		if (ph == PH_PREFIX) begin
			msg_left = {msg_left[23:0], b};
			if (pre_cnt + 1 >= PREFIX_BYTES) begin
				pre_cnt = 0;
				if (msg_left == 32'd0) begin
					r.message_done = 1'b1;
					ns_flag = 1'b0;
				end else begin
					ph = PH_KEY;
					acc = 64'd0;
					shift = 7'd0;
				end
			end else begin
				pre_cnt = pre_cnt + 1;
			end
		end else begin
			if (msg_left != 32'd0)
				msg_left = msg_left - 32'd1;
			case (ph)
				PH_KEY: begin
					r.byte_class = CLS_VARINT;
					absorb(b);
					if (!(b[7] && msg_left != 32'd0)) begin
						key = acc;
						acc = 64'd0;
						shift = 7'd0;
						if (key[2:0] == WT_VARINT) begin
							ph = PH_VALUE;
						end else if (key[2:0] == WT_LENGTH) begin
							if (key[63:3] == FIELD_NSPACE)
								kind = KIND_NSPACE;
							else if (key[63:3] == FIELD_PAYLOAD)
								kind = KIND_PAYLOAD;
							else
								kind = KIND_OTHER;
							ph = PH_LEN;
							if (msg_left == 32'd0)
								r.length_overrun = end_length(64'd0);
						end else begin
							r.parse_stopped = 1'b1;
							ph = PH_SKIP;
						end
					end
				end
				PH_VALUE: begin
					r.byte_class = CLS_VARINT;
					absorb(b);
					if (!b[7] || msg_left == 32'd0) begin
						acc = 64'd0;
						shift = 7'd0;
						ph = PH_KEY;
					end
				end
				PH_LEN: begin
					r.byte_class = CLS_VARINT;
					absorb(b);
					if (!b[7] || msg_left == 32'd0) begin
						key = acc;
						acc = 64'd0;
						shift = 7'd0;
						r.length_overrun = end_length(key);
					end
				end
				PH_STRING: begin
					case (kind)
						KIND_NSPACE:  r.byte_class = CLS_NSPACE;
						KIND_PAYLOAD: r.byte_class = CLS_PAYLOAD;
						default:      r.byte_class = CLS_OTHER;
					endcase
					if (str_left != 32'd0)
						str_left = str_left - 32'd1;
					if (str_left == 32'd0)
						ph = PH_KEY;
				end
				default: begin
					r.byte_class = CLS_SKIP;
					ph = PH_SKIP;
				end
			endcase
			if (msg_left == 32'd0) begin
				r.message_done = 1'b1;
				r.namespace_present = ns_flag;
				ns_flag = 1'b0;
				ph = PH_PREFIX;
				pre_cnt = 0;
				str_left = 32'd0;
				acc = 64'd0;
				shift = 7'd0;
				kind = KIND_NONE;
			end
		end
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		parsed_bytes.push_back(parse_byte(b));
		n_sent++;
	endtask

	// Appends a varint using the minimal number of groups plus pad extra ones.
	task automatic put_varint(input logic [63:0] v, input int pad);
		logic [69:0] w;
		int groups;
		w = {6'd0, v};
		groups = 1;
		while (groups < 10 && (w >> (7 * groups)) != 70'd0)
			groups++;
		groups = groups + pad;
		for (int i = 0; i < groups; i++) begin
			body.push_back({i != groups - 1, w[6:0]});
			w = w >> 7;
		end
	endtask

	task automatic put_key(input logic [60:0] field, input logic [2:0] wt, input int pad);
		put_varint({field, wt}, pad);
	endtask

	task automatic put_string(input logic [60:0] field, input int len);
		put_key(field, WT_LENGTH, 0);
		put_varint(64'(len), 0);
		repeat (len) body.push_back(8'($urandom_range(0, 255)));
	endtask

	// The body is cut off or padded with random bytes to the framed length.
	task automatic send_frame(input logic [31:0] len);
		sender_burst = ($urandom_range(0, 3) == 0);
		for (int i = PREFIX_BYTES - 1; i >= 0; i--)
			push_byte(len[8 * i +: 8]);
		for (int i = 0; i < len; i++)
			push_byte(i < body.size() ? body[i] : 8'($urandom_range(0, 255)));
		body.delete();
	endtask

	task automatic test_empty_frames();
		send_frame(32'd0);
		put_string(FIELD_NSPACE, 1);
		send_frame(body.size());
		send_frame(32'd0);
	endtask

	task automatic test_string_fields();
		put_string(FIELD_NSPACE, 3);
		put_string(FIELD_PAYLOAD, 2);
		put_string(61'd9, 1);
		put_key(61'd1, WT_VARINT, 0);
		put_varint(64'd300, 0);
		send_frame(body.size());
	endtask

	task automatic test_namespace_cleared();
		put_string(FIELD_NSPACE, 2);
		put_string(FIELD_NSPACE, 0);
		send_frame(body.size());
	endtask

	task automatic test_unsupported_wire();
		put_key(61'd2, WT_VARINT, 0);
		put_varint(64'h7F, 0);
		put_key(61'd3, 3'd5, 0);
		body.push_back(8'h80);
		body.push_back(8'hFF);
		body.push_back(8'h00);
		send_frame(body.size());
	endtask

	task automatic test_overrun();
		put_string(FIELD_NSPACE, 1);
		put_key(FIELD_NSPACE, WT_LENGTH, 0);
		put_varint(64'd50, 0);
		put_string(FIELD_PAYLOAD, 1);
		send_frame(body.size());
	endtask

	task automatic test_long_varints();
		put_key(61'd1, WT_VARINT, 3);
		put_varint(64'hFFFF_FFFF_FFFF_FFFF, 2);
		put_key(61'h1FFF_FFFF_FFFF_FFFF, WT_LENGTH, 0);
		put_varint(64'h8000_0000_0000_0000, 0);
		send_frame(body.size());
	endtask

	task automatic test_cut_offs();
		body.push_back(8'hA2);
		send_frame(32'd1);
		body.push_back(8'h8D);
		send_frame(32'd1);
		put_key(FIELD_PAYLOAD, WT_LENGTH, 0);
		body.push_back(8'h85);
		send_frame(32'd2);
		put_key(61'd1, WT_VARINT, 0);
		body.push_back(8'hFF);
		send_frame(32'd2);
		put_string(FIELD_NSPACE, 2);
		put_key(FIELD_NSPACE, WT_LENGTH, 0);
		send_frame(body.size());
	endtask

	task automatic test_random_frames(input int target);
		int nf;
		int sel;
		int len;
		int pad;
		logic [2:0] wt;
		logic [60:0] field;
		logic [63:0] enc;
		while (n_sent < target) begin
			if ($urandom_range(0, 19) == 0) begin
				send_frame($urandom_range(1, 30));
			end else begin
				nf = $urandom_range(0, 5);
				repeat (nf) begin
					sel = $urandom_range(0, 19);
					pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
					if ($urandom_range(0, 7) == 0)
						field = 61'({$urandom, $urandom});
					else
						field = 61'($urandom_range(1, 15));
					if (sel < 6) begin
						put_key(field, WT_VARINT, pad);
						put_varint({$urandom, $urandom} >> $urandom_range(0, 63), pad);
					end else if (sel < 17) begin
						case ($urandom_range(0, 2))
							0: field = FIELD_NSPACE;
							1: field = FIELD_PAYLOAD;
							default: ;
						endcase
						if ($urandom_range(0, 29) == 0)
							len = $urandom_range(120, 260);
						else
							len = $urandom_range(0, 8);
						enc = 64'(len);
						if ($urandom_range(0, 9) == 0) begin
							if ($urandom_range(0, 2) == 0)
								enc = {$urandom, $urandom};
							else
								enc = 64'(len + $urandom_range(1, 300));
						end
						put_key(field, WT_LENGTH, pad);
						put_varint(enc, 0);
						repeat (len) body.push_back(8'($urandom_range(0, 255)));
					end else begin
						wt = 3'($urandom_range(1, 6));
						if (wt >= WT_LENGTH)
							wt = wt + 3'd1;
						put_key(field, wt, pad);
						repeat ($urandom_range(0, 4))
							body.push_back(8'($urandom_range(0, 255)));
					end
				end
				len = body.size();
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(0, body.size() + 4);
				send_frame(len);
			end
		end
	endtask

	// A frame of the largest length, left open when the stream stops.
	task automatic test_unterminated_frame();
		sender_burst = 1'b0;
		repeat (PREFIX_BYTES) push_byte(8'hFF);
		repeat (20) push_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (ready_left == 0) begin
				ready_burst = ($urandom_range(0, 3) == 0);
				ready_left = $urandom_range(10, 60);
			end
			ready_left--;
			hold = ready_burst ? 0 : $urandom_range(0, 9);
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_bytes.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected result: data %h user %h last %b",
						m_tdata, m_tuser, m_tlast);
				n_bad++;
			end else begin
				want = parsed_bytes.pop_front();
				if (m_tdata !== want.echo_byte || m_tuser[2:0] !== want.byte_class ||
					m_tuser[3] !== want.namespace_present ||
					m_tuser[4] !== want.parse_stopped ||
					m_tuser[5] !== want.length_overrun ||
					m_tlast !== want.message_done) begin
					if (n_bad < 10)
						$display({"mismatch: expected data %h class %0d last %b ns %b ",
							"stop %b ovr %b, got data %h class %0d last %b ns %b ",
							"stop %b ovr %b"},
							want.echo_byte, want.byte_class, want.message_done,
							want.namespace_present, want.parse_stopped,
							want.length_overrun, m_tdata, m_tuser[2:0], m_tlast,
							m_tuser[3], m_tuser[4], m_tuser[5]);
					n_bad++;
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_frames();
		test_string_fields();
		test_namespace_cleared();
		test_unsupported_wire();
		test_overrun();
		test_long_varints();
		test_cut_offs();
		test_random_frames(n_sent + RANDOM_BYTES);
		test_unterminated_frame();
		s_tvalid <= 1'b0;
		while (parsed_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_bad == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
